FILE: design/obb_separating_axis_test_unit_assert.svh
// Assertion macros for the oriented box test unit.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef OBB_SEPARATING_AXIS_TEST_UNIT_ASSERT_SVH
`define OBB_SEPARATING_AXIS_TEST_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the trigger.
`define OBB_SAT_ASSERT_SAME(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the trigger.
`define OBB_SAT_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/obb_sat_pkg.sv
// ----------------------------------------------------------------------------
// obb_sat_pkg
// Shared types, codes and helper functions of the oriented box test unit.
// ----------------------------------------------------------------------------
package obb_sat_pkg;

    localparam int COORD_WIDTH_DEF   = 24;
    localparam int FRACTION_BITS_DEF = 12;
    localparam int ADDR_W            = 5;
    localparam int NUM_ENTRIES       = 30;

    localparam logic [2:0] VEC_CENTER = 3'd0;
    localparam logic [2:0] VEC_X_AXIS = 3'd1;
    localparam logic [2:0] VEC_HALF   = 3'd4;

    // Decoded control part of one request.
    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic              store;
        logic              run;
    } item_ctrl_t;

    typedef struct packed {
        logic start;
    } mul_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_sts_t;

    typedef struct packed {
        logic [2:0] q;
        logic [1:0] r;
    } div3_t;

    // Storage address of one component: box * 15 + vector * 3 + component.
    function automatic logic [ADDR_W-1:0] comp_addr(input logic box,
                                                    input logic [2:0] vec,
                                                    input logic [1:0] comp);
        logic [ADDR_W-1:0] base;
        base = box ? 5'd15 : 5'd0;
        return base + 5'({vec, 1'b0}) + 5'(vec) + 5'(comp);
    endfunction

    // Quotient and remainder by three for values up to fourteen.
    function automatic div3_t split3(input logic [3:0] n);
        div3_t res;
        res.q = 3'(n >= 4'd3) + 3'(n >= 4'd6) + 3'(n >= 4'd9) + 3'(n >= 4'd12);
        res.r = 2'(n - 4'(res.q) * 4'd3);
        return res;
    endfunction

    // Cross product terms: even steps add u[a]*v[b], odd steps subtract.
    function automatic logic [1:0] cross_u(input logic [2:0] m);
        logic [1:0] idx;
        case (m)
            3'd0:    idx = 2'd1;
            3'd1:    idx = 2'd2;
            3'd2:    idx = 2'd2;
            3'd3:    idx = 2'd0;
            3'd4:    idx = 2'd0;
            default: idx = 2'd1;
        endcase
        return idx;
    endfunction

    function automatic logic [1:0] cross_v(input logic [2:0] m);
        logic [1:0] idx;
        case (m)
            3'd0:    idx = 2'd2;
            3'd1:    idx = 2'd1;
            3'd2:    idx = 2'd0;
            3'd3:    idx = 2'd2;
            3'd4:    idx = 2'd1;
            default: idx = 2'd0;
        endcase
        return idx;
    endfunction

endpackage

FILE: design/obb_sat_front.sv
// ----------------------------------------------------------------------------
// obb_sat_front
// Accepts requests, decodes the storage address and holds them in a queue.
// ----------------------------------------------------------------------------
module obb_sat_front #(
    parameter int COORD_WIDTH = obb_sat_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          box_select,
    input  logic [2:0]                    vector_select,
    input  logic signed [COORD_WIDTH-1:0] comp_x,
    input  logic signed [COORD_WIDTH-1:0] comp_y,
    input  logic signed [COORD_WIDTH-1:0] comp_z,
    input  logic                          run_test,
    output logic                          item_valid,
    input  logic                          item_pop,
    output obb_sat_pkg::item_ctrl_t       item_ctrl,
    output logic [COORD_WIDTH-1:0]        item_x,
    output logic [COORD_WIDTH-1:0]        item_y,
    output logic [COORD_WIDTH-1:0]        item_z
);

    obb_sat_pkg::item_ctrl_t ctrl_mem [2];
    logic [COORD_WIDTH-1:0]  x_mem [2];
    logic [COORD_WIDTH-1:0]  y_mem [2];
    logic [COORD_WIDTH-1:0]  z_mem [2];
    logic                    wr_ptr_reg;
    logic                    rd_ptr_reg;
    logic [1:0]              count_reg;
    obb_sat_pkg::item_ctrl_t dec;
    logic                    do_push;
    logic                    do_pop;

    // Codes above the half size vector store nothing.
    always_comb
    begin
        dec.store = (vector_select <= obb_sat_pkg::VEC_HALF);
        dec.run   = run_test;
        dec.base  = obb_sat_pkg::comp_addr(box_select, vector_select, 2'd0);
    end

    assign full       = (count_reg == 2'd2);
    assign item_valid = (count_reg != 2'd0);
    assign do_push    = push && !full;
    assign do_pop     = item_pop && item_valid;
    assign item_ctrl  = ctrl_mem[rd_ptr_reg];
    assign item_x     = x_mem[rd_ptr_reg];
    assign item_y     = y_mem[rd_ptr_reg];
    assign item_z     = z_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ctrl_mem[wr_ptr_reg] <= dec;
            x_mem[wr_ptr_reg]    <= comp_x;
            y_mem[wr_ptr_reg]    <= comp_y;
            z_mem[wr_ptr_reg]    <= comp_z;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

FILE: design/obb_sat_mul.sv
// ----------------------------------------------------------------------------
// obb_sat_mul
// Radix-two signed shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module obb_sat_mul #(
    parameter int A_WIDTH = 112,
    parameter int B_WIDTH = 25
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  obb_sat_pkg::mul_req_t     req,
    output obb_sat_pkg::mul_sts_t     sts,
    input  logic signed [A_WIDTH-1:0] op_a,
    input  logic signed [B_WIDTH-1:0] op_b,
    output logic signed [A_WIDTH-1:0] product
);

    localparam int CNT_W = $clog2(B_WIDTH + 1);

    logic signed [A_WIDTH-1:0] a_reg;
    logic [B_WIDTH-1:0]        b_reg;
    logic signed [A_WIDTH-1:0] acc_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic signed [A_WIDTH-1:0] addend;

    // The top multiplier bit carries negative weight.
    always_comb
    begin
        if (!b_reg[B_WIDTH-1])
        begin
            addend = '0;
        end
        else if (cnt_reg == CNT_W'(B_WIDTH))
        begin
            addend = -a_reg;
        end
        else
        begin
            addend = a_reg;
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign product  = acc_reg;

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= op_a;
            b_reg   <= op_b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= (acc_reg <<< 1) + addend;
            b_reg   <= b_reg << 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(B_WIDTH);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: design/obb_sat_back.sv
// ----------------------------------------------------------------------------
// obb_sat_back
// Box storage, the fifteen-axis test sequencer and the result register.
// ----------------------------------------------------------------------------
module obb_sat_back #(
    parameter int COORD_WIDTH   = obb_sat_pkg::COORD_WIDTH_DEF,
    parameter int FRACTION_BITS = obb_sat_pkg::FRACTION_BITS_DEF,
    parameter int A_WIDTH       = 4 * COORD_WIDTH + FRACTION_BITS + 8,
    parameter int B_WIDTH       = COORD_WIDTH + 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_pop,
    input  obb_sat_pkg::item_ctrl_t       item_ctrl,
    input  logic [COORD_WIDTH-1:0]        item_x,
    input  logic [COORD_WIDTH-1:0]        item_y,
    input  logic [COORD_WIDTH-1:0]        item_z,
    output obb_sat_pkg::mul_req_t         mul_req,
    input  obb_sat_pkg::mul_sts_t         mul_sts,
    output logic signed [A_WIDTH-1:0]     mul_a,
    output logic signed [B_WIDTH-1:0]     mul_b,
    input  logic signed [A_WIDTH-1:0]     mul_p,
    output logic                          empty,
    input  logic                          pop,
    output logic                          collides
);

    localparam int W  = COORD_WIDTH;
    localparam int AW = obb_sat_pkg::ADDR_W;
    localparam int NE = obb_sat_pkg::NUM_ENTRIES;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_WR     = 3'd1;
    localparam logic [2:0] S_AXIS   = 3'd2;
    localparam logic [2:0] S_RDA    = 3'd3;
    localparam logic [2:0] S_RDB    = 3'd4;
    localparam logic [2:0] S_ISSUE  = 3'd5;
    localparam logic [2:0] S_WAIT   = 3'd6;
    localparam logic [2:0] S_CMP    = 3'd7;

    localparam logic [2:0] PH_DIFF  = 3'd0;
    localparam logic [2:0] PH_LOADL = 3'd1;
    localparam logic [2:0] PH_CROSS = 3'd2;
    localparam logic [2:0] PH_DOT   = 3'd3;
    localparam logic [2:0] PH_PROJ  = 3'd4;
    localparam logic [2:0] PH_HALF  = 3'd5;
    localparam logic [2:0] PH_CMP   = 3'd6;
    localparam logic [2:0] PH_OUT   = 3'd7;

    logic [2:0]              state_reg;
    logic [2:0]              phase_reg;
    logic [2:0]              cnt_reg;
    logic [2:0]              k_reg;
    logic [3:0]              axis_reg;
    obb_sat_pkg::item_ctrl_t ctrl_reg;
    logic [W-1:0]            cx_reg;
    logic [W-1:0]            cy_reg;
    logic [W-1:0]            cz_reg;
    logic [W-1:0]            mem [NE];
    logic [NE-1:0]           valid_reg;
    logic [W-1:0]            rd_data_reg;
    logic [W-1:0]            opa_reg;
    logic signed [W:0]       d_reg [3];
    logic signed [A_WIDTH-1:0] l_reg [3];
    logic signed [A_WIDTH-1:0] acc_reg;
    logic [A_WIDTH-1:0]      lhs_reg;
    logic [A_WIDTH-1:0]      rhs_reg;
    logic                    res_valid_reg;
    logic                    res_reg;
    logic                    sep_bit_reg;

    obb_sat_pkg::div3_t      sp;
    obb_sat_pkg::div3_t      sc;
    obb_sat_pkg::div3_t      sk;
    logic [AW-1:0]           addr_a;
    logic [AW-1:0]           addr_b;
    logic [AW-1:0]           rd_addr;
    logic [AW-1:0]           wr_addr;
    logic [W-1:0]            wr_data;
    logic                    wr_en;
    logic [1:0]              ci;
    logic signed [A_WIDTH-1:0] sum;
    logic signed [A_WIDTH-1:0] sum_abs;
    logic signed [A_WIDTH-1:0] p_abs;
    logic                    is_mul;

    assign ci      = cnt_reg[1:0];
    assign sp      = obb_sat_pkg::split3(axis_reg);
    assign sc      = obb_sat_pkg::split3(4'(axis_reg - 4'd6));
    assign sk      = obb_sat_pkg::split3({1'b0, k_reg});
    assign is_mul  = (phase_reg == PH_CROSS) || (phase_reg == PH_DOT) ||
                     (phase_reg == PH_PROJ) || (phase_reg == PH_HALF);
    assign sum     = (ci == 2'd0) ? mul_p : acc_reg + mul_p;
    assign sum_abs = sum[A_WIDTH-1] ? -sum : sum;
    assign p_abs   = mul_p[A_WIDTH-1] ? -mul_p : mul_p;

    // Read addresses of the two operands of the current step.
    always_comb
    begin
        addr_a = '0;
        addr_b = '0;
        case (phase_reg)
            PH_DIFF:
            begin
                addr_a = obb_sat_pkg::comp_addr(1'b0, obb_sat_pkg::VEC_CENTER, ci);
                addr_b = obb_sat_pkg::comp_addr(1'b1, obb_sat_pkg::VEC_CENTER, ci);
            end
            PH_LOADL:
            begin
                addr_b = obb_sat_pkg::comp_addr(sp.q[0],
                             obb_sat_pkg::VEC_X_AXIS + {1'b0, sp.r}, ci);
            end
            PH_CROSS:
            begin
                addr_a = obb_sat_pkg::comp_addr(1'b0,
                             obb_sat_pkg::VEC_X_AXIS + {1'b0, sc.q[1:0]},
                             obb_sat_pkg::cross_u(cnt_reg));
                addr_b = obb_sat_pkg::comp_addr(1'b1,
                             obb_sat_pkg::VEC_X_AXIS + {1'b0, sc.r},
                             obb_sat_pkg::cross_v(cnt_reg));
            end
            PH_PROJ:
            begin
                addr_b = obb_sat_pkg::comp_addr(sk.q[0],
                             obb_sat_pkg::VEC_X_AXIS + {1'b0, sk.r}, ci);
            end
            PH_HALF:
            begin
                addr_b = obb_sat_pkg::comp_addr(sk.q[0], obb_sat_pkg::VEC_HALF, sk.r);
            end
            default:
            begin
                addr_a = '0;
                addr_b = '0;
            end
        endcase
    end

    assign rd_addr = (state_reg == S_RDA) ? addr_a : addr_b;
    assign wr_en   = (state_reg == S_WR) && ctrl_reg.store;
    assign wr_addr = ctrl_reg.base + AW'(ci);

    always_comb
    begin
        case (ci)
            2'd0:    wr_data = cx_reg;
            2'd1:    wr_data = cy_reg;
            default: wr_data = cz_reg;
        endcase
    end

    // Multiplier operands.
    always_comb
    begin
        case (phase_reg)
            PH_CROSS: mul_a = {{(A_WIDTH-W){opa_reg[W-1]}}, opa_reg};
            PH_HALF:  mul_a = acc_reg;
            default:  mul_a = l_reg[ci];
        endcase
        if (phase_reg == PH_DOT)
        begin
            mul_b = d_reg[ci];
        end
        else
        begin
            mul_b = {rd_data_reg[W-1], rd_data_reg};
        end
    end

    assign mul_req.start = (state_reg == S_ISSUE) && is_mul;
    assign item_pop      = (state_reg == S_IDLE) && item_valid;
    assign empty         = !res_valid_reg;
    assign collides      = res_reg;

    // Storage: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
    end

    // Datapath registers without reset.
    always_ff @(posedge clk)
    begin
        if (item_pop)
        begin
            ctrl_reg <= item_ctrl;
            cx_reg   <= item_x;
            cy_reg   <= item_y;
            cz_reg   <= item_z;
        end
        if (state_reg == S_RDB)
        begin
            opa_reg <= rd_data_reg;
        end
        if (state_reg == S_AXIS)
        begin
            rhs_reg <= '0;
        end
        if (state_reg == S_ISSUE && phase_reg == PH_DIFF)
        begin
            d_reg[ci] <= {rd_data_reg[W-1], rd_data_reg} - {opa_reg[W-1], opa_reg};
        end
        if (state_reg == S_ISSUE && phase_reg == PH_LOADL)
        begin
            l_reg[ci] <= {{(A_WIDTH-W){rd_data_reg[W-1]}}, rd_data_reg};
        end
        if (state_reg == S_WAIT && mul_sts.done)
        begin
            case (phase_reg)
                PH_CROSS:
                begin
                    if (!cnt_reg[0])
                    begin
                        l_reg[cnt_reg[2:1]] <= mul_p;
                    end
                    else
                    begin
                        l_reg[cnt_reg[2:1]] <= l_reg[cnt_reg[2:1]] - mul_p;
                    end
                end
                PH_DOT:
                begin
                    acc_reg <= sum;
                    lhs_reg <= sum_abs <<< FRACTION_BITS;
                end
                PH_PROJ:
                begin
                    acc_reg <= sum;
                end
                PH_HALF:
                begin
                    rhs_reg <= rhs_reg + p_abs;
                end
                default:
                begin
                    acc_reg <= acc_reg;
                end
            endcase
        end
        if (phase_reg == PH_CMP && state_reg == S_CMP)
        begin
            sep_bit_reg <= (lhs_reg > rhs_reg);
        end
    end

    // Sequencer. The compare and result steps share one state code and are
    // told apart by the phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_DIFF;
            cnt_reg       <= 3'd0;
            k_reg         <= 3'd0;
            axis_reg      <= 4'd0;
            valid_reg     <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= 1'b0;
        end
        else
        begin
            if (pop && res_valid_reg)
            begin
                res_valid_reg <= 1'b0;
            end
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        cnt_reg   <= 3'd0;
                        state_reg <= S_WR;
                    end
                end
                S_WR:
                begin
                    if (cnt_reg == 3'd2)
                    begin
                        cnt_reg <= 3'd0;
                        if (ctrl_reg.run)
                        begin
                            phase_reg <= PH_DIFF;
                            axis_reg  <= 4'd0;
                            state_reg <= S_RDA;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 3'd1;
                    end
                end
                S_AXIS:
                begin
                    cnt_reg   <= 3'd0;
                    phase_reg <= (axis_reg < 4'd6) ? PH_LOADL : PH_CROSS;
                    state_reg <= S_RDA;
                end
                S_RDA:
                begin
                    state_reg <= S_RDB;
                end
                S_RDB:
                begin
                    state_reg <= S_ISSUE;
                end
                S_ISSUE:
                begin
                    case (phase_reg)
                        PH_DIFF:
                        begin
                            if (cnt_reg == 3'd2)
                            begin
                                state_reg <= S_AXIS;
                            end
                            else
                            begin
                                cnt_reg   <= cnt_reg + 3'd1;
                                state_reg <= S_RDA;
                            end
                        end
                        PH_LOADL:
                        begin
                            if (cnt_reg == 3'd2)
                            begin
                                cnt_reg   <= 3'd0;
                                phase_reg <= PH_DOT;
                                state_reg <= S_ISSUE;
                            end
                            else
                            begin
                                cnt_reg   <= cnt_reg + 3'd1;
                                state_reg <= S_RDA;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_WAIT;
                        end
                    endcase
                end
                S_WAIT:
                begin
                    if (mul_sts.done)
                    begin
                        case (phase_reg)
                            PH_CROSS:
                            begin
                                if (cnt_reg == 3'd5)
                                begin
                                    cnt_reg   <= 3'd0;
                                    phase_reg <= PH_DOT;
                                    state_reg <= S_ISSUE;
                                end
                                else
                                begin
                                    cnt_reg   <= cnt_reg + 3'd1;
                                    state_reg <= S_RDA;
                                end
                            end
                            PH_DOT:
                            begin
                                if (cnt_reg == 3'd2)
                                begin
                                    cnt_reg   <= 3'd0;
                                    k_reg     <= 3'd0;
                                    phase_reg <= PH_PROJ;
                                    state_reg <= S_RDA;
                                end
                                else
                                begin
                                    cnt_reg   <= cnt_reg + 3'd1;
                                    state_reg <= S_ISSUE;
                                end
                            end
                            PH_PROJ:
                            begin
                                if (cnt_reg == 3'd2)
                                begin
                                    phase_reg <= PH_HALF;
                                end
                                else
                                begin
                                    cnt_reg <= cnt_reg + 3'd1;
                                end
                                state_reg <= S_RDA;
                            end
                            default:
                            begin
                                cnt_reg <= 3'd0;
                                if (k_reg == 3'd5)
                                begin
                                    phase_reg <= PH_CMP;
                                    state_reg <= S_CMP;
                                end
                                else
                                begin
                                    k_reg     <= k_reg + 3'd1;
                                    phase_reg <= PH_PROJ;
                                    state_reg <= S_RDA;
                                end
                            end
                        endcase
                    end
                end
                default:
                begin
                    if (phase_reg == PH_CMP)
                    begin
                        // The compare result lands in sep_bit_reg this edge.
                        phase_reg <= PH_OUT;
                    end
                    else if (sep_bit_reg || axis_reg == 4'd14)
                    begin
                        if (!res_valid_reg)
                        begin
                            res_valid_reg <= 1'b1;
                            res_reg       <= !sep_bit_reg;
                            state_reg     <= S_IDLE;
                        end
                    end
                    else
                    begin
                        axis_reg  <= axis_reg + 4'd1;
                        state_reg <= S_AXIS;
                    end
                end
            endcase
        end
    end

endmodule

FILE: design/obb_separating_axis_test_unit.sv
// ----------------------------------------------------------------------------
// obb_separating_axis_test_unit: oriented box overlap test, exact fixed point.
// A load request is stored one component at a time; the two-entry request queue
// hides that. A test runs up to 459 shift-add multiplies, all on the one
// bit-serial multiplier. Reset empties the request queue and the result
// register and reads stored data as zero.
// ----------------------------------------------------------------------------
module obb_separating_axis_test_unit #(
    parameter int COORD_WIDTH   = obb_sat_pkg::COORD_WIDTH_DEF,
    parameter int FRACTION_BITS = obb_sat_pkg::FRACTION_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          box_select,
    input  logic [2:0]                    vector_select,
    input  logic signed [COORD_WIDTH-1:0] comp_x,
    input  logic signed [COORD_WIDTH-1:0] comp_y,
    input  logic signed [COORD_WIDTH-1:0] comp_z,
    input  logic                          run_test,
    output logic                          empty,
    input  logic                          pop,
    output logic                          collides
);

    `include "obb_separating_axis_test_unit_assert.svh"

    // The product register holds the widest term, a half size times a
    // projection onto a cross axis, plus room for the shifted center term.
    localparam int A_WIDTH = 4 * COORD_WIDTH + FRACTION_BITS + 8;
    localparam int B_WIDTH = COORD_WIDTH + 1;

    logic                       item_valid;
    logic                       item_pop;
    obb_sat_pkg::item_ctrl_t    item_ctrl;
    logic [COORD_WIDTH-1:0]     item_x;
    logic [COORD_WIDTH-1:0]     item_y;
    logic [COORD_WIDTH-1:0]     item_z;
    obb_sat_pkg::mul_req_t      mul_req;
    obb_sat_pkg::mul_sts_t      mul_sts;
    logic signed [A_WIDTH-1:0]  mul_a;
    logic signed [B_WIDTH-1:0]  mul_b;
    logic signed [A_WIDTH-1:0]  mul_p;

    // The front decodes each request and queues it, so the requester can keep
    // loading while a test is running.
    obb_sat_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .box_select   (box_select),
        .vector_select(vector_select),
        .comp_x       (comp_x),
        .comp_y       (comp_y),
        .comp_z       (comp_z),
        .run_test     (run_test),
        .item_valid   (item_valid),
        .item_pop     (item_pop),
        .item_ctrl    (item_ctrl),
        .item_x       (item_x),
        .item_y       (item_y),
        .item_z       (item_z)
    );

    // The back stores the boxes and steps through the fifteen axes, stopping
    // at the first one that separates the boxes.
    obb_sat_back #(
        .COORD_WIDTH  (COORD_WIDTH),
        .FRACTION_BITS(FRACTION_BITS),
        .A_WIDTH      (A_WIDTH),
        .B_WIDTH      (B_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_valid(item_valid),
        .item_pop  (item_pop),
        .item_ctrl (item_ctrl),
        .item_x    (item_x),
        .item_y    (item_y),
        .item_z    (item_z),
        .mul_req   (mul_req),
        .mul_sts   (mul_sts),
        .mul_a     (mul_a),
        .mul_b     (mul_b),
        .mul_p     (mul_p),
        .empty     (empty),
        .pop       (pop),
        .collides  (collides)
    );

    // All products of the test go through this one multiplier.
    obb_sat_mul #(
        .A_WIDTH(A_WIDTH),
        .B_WIDTH(B_WIDTH)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mul_req),
        .sts    (mul_sts),
        .op_a   (mul_a),
        .op_b   (mul_b),
        .product(mul_p)
    );

    // The sequencer must never restart the multiplier in the middle of a product.
    `OBB_SAT_ASSERT_SAME(a_mul_idle_on_start, mul_req.start, !mul_sts.busy, "multiplier restarted while busy")
    // A started product keeps the multiplier busy in the next cycle.
    `OBB_SAT_ASSERT_NEXT(a_mul_busy_after_start, mul_req.start, mul_sts.busy, "multiplier did not start")
    // An accepted request is visible to the back in the next cycle.
    `OBB_SAT_ASSERT_NEXT(a_queue_holds_request, push && !full, item_valid, "accepted request lost")

endmodule
